// ----- design/calrec_pkg.sv -----
// ----------------------------------------------------------------------------
// Calibration record codec package
// Shared constants, result codes and helper functions for the record codec.
// ----------------------------------------------------------------------------
package calrec_pkg;

  // Record layout.
  localparam logic [3:0]  REC_LEN       = 4'd12;
  localparam logic [3:0]  REC_LAST      = 4'd11;
  localparam logic [3:0]  CRC_SPAN      = 4'd10;
  localparam logic [31:0] MAGIC_WORD    = 32'h4C43414C;
  localparam logic [15:0] FMT_VERSION   = 16'h0001;

  // CRC-16/CCITT-FALSE.
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;

  // Reset value of the least accepted magnitude (1e-6 as binary32 bits).
  localparam logic [30:0] MIN_MAG_RESET = 31'h358637BD;

  typedef enum logic {
    MODE_DECODE = 1'b0,
    MODE_ENCODE = 1'b1
  } mode_t;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_BYTE    = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_BAD_CRC     = 3'd4,
    ST_BAD_FACTOR  = 3'd5
  } status_t;

  // One byte of the MSB-first CRC update, unrolled over its eight bits.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // A factor is usable when it is finite and its magnitude reaches the floor.
  function automatic logic factor_ok(input logic [31:0] bits, input logic [30:0] min_mag);
    return (bits[30:23] != 8'hFF) && (bits[30:0] >= min_mag);
  endfunction

  // Expected magic byte at record position 0..3.
  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = MAGIC_WORD[7:0];
      2'd1:    b = MAGIC_WORD[15:8];
      2'd2:    b = MAGIC_WORD[23:16];
      2'd3:    b = MAGIC_WORD[31:24];
      default: b = MAGIC_WORD[7:0];
    endcase
    return b;
  endfunction

  // Byte of an encoded record at position idx, given the factor and the CRC.
  function automatic logic [7:0] enc_byte(input logic [3:0] idx, input logic [31:0] factor,
                                          input logic [15:0] crc);
    logic [7:0] b;
    unique case (idx)
      4'd0, 4'd1, 4'd2, 4'd3: b = magic_byte(idx[1:0]);
      4'd4:    b = FMT_VERSION[7:0];
      4'd5:    b = FMT_VERSION[15:8];
      4'd6:    b = factor[7:0];
      4'd7:    b = factor[15:8];
      4'd8:    b = factor[23:16];
      4'd9:    b = factor[31:24];
      4'd10:   b = crc[7:0];
      4'd11:   b = crc[15:8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- design/calrec_in_if.sv -----
// ----------------------------------------------------------------------------
// Calibration record codec input channel
// Valid/ready channel carrying one decode byte or one factor to encode.
// ----------------------------------------------------------------------------
interface calrec_in_if import calrec_pkg::*;;
  logic        valid;
  logic        ready;
  mode_t       mode;
  logic [7:0]  data_byte;
  logic        record_end;
  logic [31:0] factor_in;

  modport source (output valid, output mode, output data_byte, output record_end,
                  output factor_in, input ready);
  modport sink   (input valid, input mode, input data_byte, input record_end,
                  input factor_in, output ready);
endinterface

// ----- design/calrec_out_if.sv -----
// ----------------------------------------------------------------------------
// Calibration record codec result channel
// Valid/ready channel carrying one verdict or one encoded record byte.
// ----------------------------------------------------------------------------
interface calrec_out_if import calrec_pkg::*;;
  logic        valid;
  logic        ready;
  kind_t       result_kind;
  status_t     status;
  logic [31:0] factor_out;
  logic [7:0]  record_byte;
  logic        last;

  modport source (output valid, output result_kind, output status, output factor_out,
                  output record_byte, output last, input ready);
  modport sink   (input valid, input result_kind, input status, input factor_out,
                  input record_byte, input last, output ready);
endinterface

// ----- design/calrec_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Calibration record codec configuration channel
// Valid/ready write channel for the least accepted factor magnitude.
// ----------------------------------------------------------------------------
interface calrec_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] min_magnitude_bits;

  modport source (output valid, output min_magnitude_bits, input ready);
  modport sink   (input valid, input min_magnitude_bits, output ready);
endinterface

// ----- design/calibration_record_codec.sv -----
// ----------------------------------------------------------------------------
// Calibration record codec
// Streaming decoder and encoder for the 12-byte CRC-protected record.
// ----------------------------------------------------------------------------
// Usage:
// - in_chan takes one beat per item. In decode mode each beat is one record
//   byte; the beat with record_end set closes the record and yields a single
//   verdict beat. Other decode beats yield nothing. In encode mode a beat
//   carries a factor and yields twelve record-byte beats, or one rejection
//   verdict when the factor is not finite or below the magnitude floor.
// - out_chan delivers results; last marks the final beat of each run.
// - cfg_chan writes the magnitude floor; it is always ready and takes effect
//   on the next item. Write it only while the block is idle.
// - An item passes through the input register, then the result register,
//   before its first result beat appears on out_chan.
// - Throughput: one decode byte per cycle. An encode occupies the result
//   register for its twelve record bytes, and later items wait in the input
//   register meanwhile; the CRC covers bytes 0..9, one folded per beat.
// - Reset clears the decode state, empties both registers and restores the
//   floor to 1e-6. When the receiver stalls, the result register holds and
//   in_chan.ready drops while an item waits in the input register.
// ----------------------------------------------------------------------------
module calibration_record_codec import calrec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  calrec_in_if.sink    in_chan,
  calrec_out_if.source out_chan,
  calrec_cfg_if.sink   cfg_chan
);

  // Configuration register.
  logic [30:0] min_mag_r;

  // Input register.
  logic        in_valid_r, in_valid_nxt;
  mode_t       in_mode_r;
  logic [7:0]  in_byte_r;
  logic        in_end_r;
  logic [31:0] in_factor_r;

  // Decode state.
  logic [3:0]  byte_count_r, byte_count_nxt;
  logic [15:0] run_crc_r, run_crc_nxt;
  logic        magic_ok_r, magic_ok_nxt;
  logic        version_ok_r, version_ok_nxt;
  logic [31:0] factor_bytes_r, factor_bytes_nxt;
  logic [15:0] stored_crc_r, stored_crc_nxt;

  // Encode sequencer.
  logic        enc_busy_r, enc_busy_nxt;
  logic [3:0]  enc_idx_r, enc_idx_nxt;
  logic [15:0] enc_crc_r, enc_crc_nxt;
  logic [31:0] enc_factor_r, enc_factor_nxt;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [31:0] out_factor_r, out_factor_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  // Working signals.
  logic        out_free;
  logic        consume;
  logic        emit;
  logic [31:0] src_factor;
  logic [3:0]  src_idx;
  logic [15:0] src_crc;
  logic [7:0]  src_byte;
  logic [15:0] src_crc_upd;
  logic [3:0]  upd_count;
  logic [15:0] upd_crc;
  logic        upd_magic;
  logic        upd_version;
  logic [31:0] upd_factor;
  logic [15:0] upd_stored;
  status_t     verdict;

  assign out_free = !out_valid_r || out_chan.ready;

  // Byte source for the encoder: a running encode, or the first byte of a new one.
  always_comb begin
    src_factor  = enc_busy_r ? enc_factor_r : in_factor_r;
    src_idx     = enc_busy_r ? enc_idx_r : 4'd0;
    src_crc     = enc_busy_r ? enc_crc_r : CRC_INIT;
    src_byte    = enc_byte(src_idx, src_factor, src_crc);
    src_crc_upd = (src_idx < CRC_SPAN) ? crc_byte(src_crc, src_byte) : src_crc;
  end

  // Decode state after folding in the byte held in the input register.
  always_comb begin
    upd_count   = byte_count_r;
    upd_crc     = run_crc_r;
    upd_magic   = magic_ok_r;
    upd_version = version_ok_r;
    upd_factor  = factor_bytes_r;
    upd_stored  = stored_crc_r;
    if (byte_count_r < REC_LEN) begin
      upd_count = byte_count_r + 4'd1;
      if (byte_count_r < CRC_SPAN) begin
        upd_crc = crc_byte(run_crc_r, in_byte_r);
      end
      unique case (byte_count_r)
        4'd0, 4'd1, 4'd2, 4'd3: begin
          if (in_byte_r != magic_byte(byte_count_r[1:0])) upd_magic = 1'b0;
        end
        4'd4: begin
          if (in_byte_r != FMT_VERSION[7:0]) upd_version = 1'b0;
        end
        4'd5: begin
          if (in_byte_r != FMT_VERSION[15:8]) upd_version = 1'b0;
        end
        4'd6:  upd_factor[7:0]   = factor_bytes_r[7:0] | in_byte_r;
        4'd7:  upd_factor[15:8]  = factor_bytes_r[15:8] | in_byte_r;
        4'd8:  upd_factor[23:16] = factor_bytes_r[23:16] | in_byte_r;
        4'd9:  upd_factor[31:24] = factor_bytes_r[31:24] | in_byte_r;
        4'd10: upd_stored[7:0]   = stored_crc_r[7:0] | in_byte_r;
        4'd11: upd_stored[15:8]  = stored_crc_r[15:8] | in_byte_r;
        default: ;
      endcase
    end
  end

  // Verdict checks in priority order.
  always_comb begin
    priority if (upd_count < REC_LEN) begin
      verdict = ST_SHORT;
    end else if (!upd_magic) begin
      verdict = ST_BAD_MAGIC;
    end else if (!upd_version) begin
      verdict = ST_BAD_VERSION;
    end else if (upd_stored != upd_crc) begin
      verdict = ST_BAD_CRC;
    end else if (!factor_ok(upd_factor, min_mag_r)) begin
      verdict = ST_BAD_FACTOR;
    end else begin
      verdict = ST_OK;
    end
  end

  // Main control: encoder sequencing, decode updates and result loading.
  always_comb begin
    consume          = 1'b0;
    emit             = 1'b0;
    byte_count_nxt   = byte_count_r;
    run_crc_nxt      = run_crc_r;
    magic_ok_nxt     = magic_ok_r;
    version_ok_nxt   = version_ok_r;
    factor_bytes_nxt = factor_bytes_r;
    stored_crc_nxt   = stored_crc_r;
    enc_busy_nxt     = enc_busy_r;
    enc_idx_nxt      = enc_idx_r;
    enc_crc_nxt      = enc_crc_r;
    enc_factor_nxt   = enc_factor_r;
    out_kind_nxt     = out_kind_r;
    out_status_nxt   = out_status_r;
    out_factor_nxt   = out_factor_r;
    out_byte_nxt     = out_byte_r;
    out_last_nxt     = out_last_r;

    priority if (enc_busy_r) begin
      // Emit the next byte of a running encode.
      if (out_free) begin
        emit           = 1'b1;
        out_kind_nxt   = KIND_BYTE;
        out_status_nxt = ST_OK;
        out_factor_nxt = 32'h0;
        out_byte_nxt   = src_byte;
        out_last_nxt   = (enc_idx_r == REC_LAST);
        enc_crc_nxt    = src_crc_upd;
        enc_idx_nxt    = enc_idx_r + 4'd1;
        if (enc_idx_r == REC_LAST) enc_busy_nxt = 1'b0;
      end
    end else if (in_valid_r && (in_mode_r == MODE_ENCODE)) begin
      // Start an encode with its first byte, or reject the factor.
      if (out_free) begin
        consume        = 1'b1;
        emit           = 1'b1;
        out_factor_nxt = 32'h0;
        if (!factor_ok(in_factor_r, min_mag_r)) begin
          out_kind_nxt   = KIND_VERDICT;
          out_status_nxt = ST_BAD_FACTOR;
          out_byte_nxt   = 8'h00;
          out_last_nxt   = 1'b1;
        end else begin
          out_kind_nxt   = KIND_BYTE;
          out_status_nxt = ST_OK;
          out_byte_nxt   = src_byte;
          out_last_nxt   = 1'b0;
          enc_busy_nxt   = 1'b1;
          enc_idx_nxt    = 4'd1;
          enc_crc_nxt    = src_crc_upd;
          enc_factor_nxt = in_factor_r;
        end
      end
    end else if (in_valid_r) begin
      // Decode byte: fold it in, and close the record on its end beat.
      if (!in_end_r) begin
        consume          = 1'b1;
        byte_count_nxt   = upd_count;
        run_crc_nxt      = upd_crc;
        magic_ok_nxt     = upd_magic;
        version_ok_nxt   = upd_version;
        factor_bytes_nxt = upd_factor;
        stored_crc_nxt   = upd_stored;
      end else if (out_free) begin
        consume          = 1'b1;
        emit             = 1'b1;
        out_kind_nxt     = KIND_VERDICT;
        out_status_nxt   = verdict;
        out_factor_nxt   = (verdict == ST_OK) ? upd_factor : 32'h0;
        out_byte_nxt     = 8'h00;
        out_last_nxt     = 1'b1;
        byte_count_nxt   = 4'd0;
        run_crc_nxt      = CRC_INIT;
        magic_ok_nxt     = 1'b1;
        version_ok_nxt   = 1'b1;
        factor_bytes_nxt = 32'h0;
        stored_crc_nxt   = 16'h0;
      end
    end else begin
      // Idle: nothing held and no encode running, so everything keeps its value.
      consume = 1'b0;
    end
  end

  // Handshake next values.
  assign in_chan.ready  = !in_valid_r || consume;
  assign in_valid_nxt   = in_chan.ready ? in_chan.valid : in_valid_r;
  assign out_valid_nxt  = emit ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  assign cfg_chan.ready = 1'b1;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mag_r      <= MIN_MAG_RESET;
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      byte_count_r   <= 4'd0;
      run_crc_r      <= CRC_INIT;
      magic_ok_r     <= 1'b1;
      version_ok_r   <= 1'b1;
      factor_bytes_r <= 32'h0;
      stored_crc_r   <= 16'h0;
      enc_busy_r     <= 1'b0;
      enc_idx_r      <= 4'd0;
    end else begin
      if (cfg_chan.valid) min_mag_r <= cfg_chan.min_magnitude_bits;
      in_valid_r     <= in_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      byte_count_r   <= byte_count_nxt;
      run_crc_r      <= run_crc_nxt;
      magic_ok_r     <= magic_ok_nxt;
      version_ok_r   <= version_ok_nxt;
      factor_bytes_r <= factor_bytes_nxt;
      stored_crc_r   <= stored_crc_nxt;
      enc_busy_r     <= enc_busy_nxt;
      enc_idx_r      <= enc_idx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_mode_r   <= in_chan.mode;
      in_byte_r   <= in_chan.data_byte;
      in_end_r    <= in_chan.record_end;
      in_factor_r <= in_chan.factor_in;
    end
    enc_crc_r    <= enc_crc_nxt;
    enc_factor_r <= enc_factor_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_factor_r <= out_factor_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Result channel outputs.
  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.factor_out  = out_factor_r;
  assign out_chan.record_byte = out_byte_r;
  assign out_chan.last        = out_last_r;

  // While an encode runs, one of its bytes always sits in the result register.
  assert property (@(posedge clk) disable iff (!rst_n) enc_busy_r |-> out_valid_r)
    else $error("encode running with an empty result register");

  // The encode position stays inside the record while the sequencer runs.
  assert property (@(posedge clk) disable iff (!rst_n)
                   enc_busy_r |-> (enc_idx_r != 4'd0) && (enc_idx_r < REC_LEN))
    else $error("encode position out of range");

  // The final byte of a record means the sequencer has finished.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r && out_last_r && (out_kind_r == KIND_BYTE) |-> !enc_busy_r)
    else $error("encode still running after its final byte");

  // A decode verdict always leaves the decode state cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
                   emit && (in_mode_r == MODE_DECODE) && !enc_busy_r |=>
                   (byte_count_r == 4'd0) && (run_crc_r == CRC_INIT))
    else $error("decode state not cleared after a verdict");

  // The byte counter saturates at the record length.
  assert property (@(posedge clk) disable iff (!rst_n) byte_count_r <= REC_LEN)
    else $error("byte counter past the record length");

endmodule
